// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OGR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OGR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ogr_pkg.sv -----
// ----------------------------------------------------------------------------
// ogr_pkg
// Types, widths and codes shared by the glyph row renderer modules.
// ----------------------------------------------------------------------------
package ogr_pkg;

  localparam int ADDR_W      = 11;
  localparam int STORE_DEPTH = 2048;
  localparam int DIM_W       = 11;
  localparam int POS_W       = 12;
  localparam int CODE_W      = 8;
  localparam int FONT_BITS   = 8;
  localparam int PROD_W      = 24;
  localparam int ACC_W       = 25;
  localparam int AREA_W      = 2 * DIM_W;
  localparam int START_W     = 23;
  localparam int MASK_BITS   = 10;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

  localparam int GLYPH_ROWS_DEF = 8;
  localparam int GLYPH_BITS_DEF = 8;
  localparam int CELL_PAD_DEF   = 2;

  // one classified word between front and back; base is signed
  typedef struct packed {
    logic                 draw;
    logic [ADDR_W-1:0]    font_address;
    logic [FONT_BITS-1:0] font_row_bits;
    logic [CODE_W-1:0]    char_code;
    logic [ACC_W-1:0]     base;
  } item_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

// ----- rtl/core/osd_glyph_row_renderer.sv -----
// ----------------------------------------------------------------------------
// osd_glyph_row_renderer
// Text mode glyph row renderer: font store loads and per-row cell masks.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------
//   item in  | start & !busy           | op font_address font_row_bits
//            |                         | char_code pos_x pos_y
//   result   | strobe (one cycle)      | row_start fg_mask write_mask last_row
//   config   | cfg_valid & cfg_ready   | cfg_index cfg_data
//
// A load word is one font store write; a draw issues one font store read
// per row for GLYPH_ROWS rows. Draw rows pass the front stage, the queue,
// the back row counter, the font store read and p1 stage, then the outputs.
// busy rises when the queue and the front stage together hold four words.
// Synchronous reset clears control state; the font store is not cleared.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module osd_glyph_row_renderer #(
  parameter int GLYPH_ROWS = ogr_pkg::GLYPH_ROWS_DEF,
  parameter int GLYPH_BITS = ogr_pkg::GLYPH_BITS_DEF,
  parameter int CELL_PAD   = ogr_pkg::CELL_PAD_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               op,
  input  logic [ogr_pkg::ADDR_W-1:0]         font_address,
  input  logic [ogr_pkg::FONT_BITS-1:0]      font_row_bits,
  input  logic [ogr_pkg::CODE_W-1:0]         char_code,
  input  logic signed [ogr_pkg::POS_W-1:0]   pos_x,
  input  logic signed [ogr_pkg::POS_W-1:0]   pos_y,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ogr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ogr_pkg::DIM_W-1:0]          cfg_data,
  output logic                               strobe,
  output logic signed [ogr_pkg::START_W-1:0] row_start,
  output logic [ogr_pkg::MASK_BITS-1:0]      fg_mask,
  output logic [ogr_pkg::MASK_BITS-1:0]      write_mask,
  output logic                               last_row
);

  logic [ogr_pkg::DIM_W-1:0] screen_width;
  logic [ogr_pkg::DIM_W-1:0] screen_height;
  logic                      push;
  logic                      pop;
  ogr_pkg::item_t            push_item;
  ogr_pkg::item_t            head;
  ogr_pkg::q_status_t        q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= ogr_pkg::WIDTH_RESET;
      screen_height <= ogr_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ogr_pkg::REG_SCREEN_WIDTH: begin
          screen_width <= cfg_data;
        end
        ogr_pkg::REG_SCREEN_HEIGHT: begin
          screen_height <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  ogr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .font_address  (font_address),
    .font_row_bits (font_row_bits),
    .char_code     (char_code),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .screen_width  (screen_width),
    .q_status      (q_status),
    .push          (push),
    .push_item     (push_item)
  );

  ogr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  ogr_back #(
    .GLYPH_ROWS (GLYPH_ROWS),
    .GLYPH_BITS (GLYPH_BITS),
    .CELL_PAD   (CELL_PAD)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .q_status      (q_status),
    .head          (head),
    .pop           (pop),
    .strobe        (strobe),
    .row_start     (row_start),
    .fg_mask       (fg_mask),
    .write_mask    (write_mask),
    .last_row      (last_row)
  );

endmodule

// ----- rtl/core/ogr_ram.sv -----
// ----------------------------------------------------------------------------
// ogr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module ogr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ogr_front.sv -----
// ----------------------------------------------------------------------------
// ogr_front
// Accepts words, forms the draw base index and hands them to the queue.
// ----------------------------------------------------------------------------
module ogr_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            op,
  input  logic [ogr_pkg::ADDR_W-1:0]      font_address,
  input  logic [ogr_pkg::FONT_BITS-1:0]   font_row_bits,
  input  logic [ogr_pkg::CODE_W-1:0]      char_code,
  input  logic signed [ogr_pkg::POS_W-1:0] pos_x,
  input  logic signed [ogr_pkg::POS_W-1:0] pos_y,
  input  logic [ogr_pkg::DIM_W-1:0]       screen_width,
  input  ogr_pkg::q_status_t              q_status,
  output logic                            push,
  output ogr_pkg::item_t                  push_item
);

  logic                               accept;
  logic [ogr_pkg::QCNT_W:0]           pending;
  logic signed [ogr_pkg::PROD_W-1:0]  prod_next;
  logic signed [ogr_pkg::ACC_W-1:0]   base_c;

  logic                               stage_valid;
  logic                               stage_draw;
  logic [ogr_pkg::ADDR_W-1:0]         stage_addr;
  logic [ogr_pkg::FONT_BITS-1:0]      stage_bits;
  logic [ogr_pkg::CODE_W-1:0]         stage_code;
  logic signed [ogr_pkg::POS_W-1:0]   stage_px;
  logic signed [ogr_pkg::PROD_W-1:0]  stage_prod;

  assign pending = {1'b0, q_status.count} + {{ogr_pkg::QCNT_W{1'b0}}, stage_valid};
  assign busy    = pending >= (ogr_pkg::QCNT_W + 1)'(ogr_pkg::QUEUE_DEPTH);
  assign accept  = start && !busy;

  assign prod_next = pos_y * $signed({1'b0, screen_width});
  assign base_c    = ogr_pkg::ACC_W'(stage_prod) + ogr_pkg::ACC_W'(stage_px);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_draw <= (op == ogr_pkg::OP_DRAW);
      stage_addr <= font_address;
      stage_bits <= font_row_bits;
      stage_code <= char_code;
      stage_px   <= pos_x;
      stage_prod <= prod_next;
    end
  end

  assign push                    = stage_valid;
  assign push_item.draw          = stage_draw;
  assign push_item.font_address  = stage_addr;
  assign push_item.font_row_bits = stage_bits;
  assign push_item.char_code     = stage_code;
  assign push_item.base          = base_c;

endmodule

// ----- rtl/core/ogr_queue.sv -----
// ----------------------------------------------------------------------------
// ogr_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ogr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ogr_pkg::item_t     push_item,
  input  logic               pop,
  output ogr_pkg::item_t     head,
  output ogr_pkg::q_status_t status
);

  ogr_pkg::item_t              entries [ogr_pkg::QUEUE_DEPTH];
  logic [ogr_pkg::QPTR_W-1:0]  wr_ptr;
  logic [ogr_pkg::QPTR_W-1:0]  rd_ptr;
  logic [ogr_pkg::QCNT_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assign head         = entries[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);

  `OGR_ASSERT_IMPL(q_no_overflow, push,
                   (count < ogr_pkg::QCNT_W'(ogr_pkg::QUEUE_DEPTH)) || pop,
                   "queue written while full")
  `OGR_ASSERT_IMPL(q_no_underflow, pop, count != '0, "queue read while empty")

endmodule

// ----- rtl/core/ogr_back.sv -----
// ----------------------------------------------------------------------------
// ogr_back
// Executes queued words: font writes, and per-row glyph reads with masks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ogr_back #(
  parameter int GLYPH_ROWS = ogr_pkg::GLYPH_ROWS_DEF,
  parameter int GLYPH_BITS = ogr_pkg::GLYPH_BITS_DEF,
  parameter int CELL_PAD   = ogr_pkg::CELL_PAD_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ogr_pkg::DIM_W-1:0]        screen_width,
  input  logic [ogr_pkg::DIM_W-1:0]        screen_height,
  input  ogr_pkg::q_status_t               q_status,
  input  ogr_pkg::item_t                   head,
  output logic                             pop,
  output logic                             strobe,
  output logic signed [ogr_pkg::START_W-1:0] row_start,
  output logic [ogr_pkg::MASK_BITS-1:0]    fg_mask,
  output logic [ogr_pkg::MASK_BITS-1:0]    write_mask,
  output logic                             last_row
);

  localparam int ROW_W      = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int CELL_WIDTH = GLYPH_BITS + CELL_PAD;
  localparam int LEFT_PAD   = CELL_PAD - CELL_PAD / 2;
  localparam logic [ROW_W-1:0] LAST_ROW_IDX = ROW_W'(GLYPH_ROWS - 1);

  logic [ogr_pkg::AREA_W-1:0]        area;
  logic                              active;
  logic [ROW_W-1:0]                  row;
  logic [ogr_pkg::CODE_W-1:0]        code;
  logic signed [ogr_pkg::ACC_W-1:0]  start;
  logic signed [ogr_pkg::ACC_W-1:0]  rem;
  logic signed [ogr_pkg::ACC_W-1:0]  width_ext;
  logic signed [ogr_pkg::ACC_W-1:0]  head_base;
  logic                              last_issue;
  logic                              load_draw;
  logic                              ram_we;
  logic [ogr_pkg::ADDR_W-1:0]        raddr;
  logic [ogr_pkg::FONT_BITS-1:0]     rdata;

  logic                              p1_valid;
  logic signed [ogr_pkg::ACC_W-1:0]  p1_start;
  logic signed [ogr_pkg::ACC_W-1:0]  p1_rem;
  logic                              p1_last;
  logic [ogr_pkg::MASK_BITS-1:0]     fg_c;
  logic [ogr_pkg::MASK_BITS-1:0]     wm_c;

  assign last_issue = active && (row == LAST_ROW_IDX);
  assign pop        = !q_status.empty && (!active || last_issue);
  assign load_draw  = pop && head.draw;
  assign ram_we     = pop && !head.draw;
  assign width_ext  = $signed(ogr_pkg::ACC_W'(screen_width));
  assign head_base  = $signed(head.base);
  assign raddr      = ogr_pkg::ADDR_W'(ogr_pkg::ADDR_W'(code) * ogr_pkg::ADDR_W'(GLYPH_ROWS))
                    + ogr_pkg::ADDR_W'(row);

  ogr_ram #(
    .WIDTH (ogr_pkg::FONT_BITS),
    .DEPTH (ogr_pkg::STORE_DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.font_address),
    .wdata (head.font_row_bits),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      p1_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      p1_valid <= active;
      strobe   <= p1_valid;
      if (load_draw) begin
        active <= 1'b1;
      end else if (last_issue) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    area <= screen_width * screen_height;
    if (load_draw) begin
      row   <= '0;
      code  <= head.char_code;
      start <= head_base;
      rem   <= $signed({{(ogr_pkg::ACC_W - ogr_pkg::AREA_W){1'b0}}, area}) - head_base;
    end else if (active) begin
      row   <= row + 1'b1;
      start <= start + width_ext;
      rem   <= rem - width_ext;
    end
    p1_start   <= start;
    p1_rem     <= rem;
    p1_last    <= last_issue;
    row_start  <= p1_start[ogr_pkg::START_W-1:0];
    fg_mask    <= fg_c;
    write_mask <= wm_c;
    last_row   <= p1_last;
  end

  // pixel i (i < CELL_WIDTH): written when start + i >= 0 and start + i < area
  for (genvar i = 0; i < ogr_pkg::MASK_BITS; i++) begin : g_pix
    localparam int K = i - LEFT_PAD;
    localparam logic signed [ogr_pkg::ACC_W-1:0] NEG_I = ogr_pkg::ACC_W'(-i);
    localparam logic signed [ogr_pkg::ACC_W-1:0] POS_I = ogr_pkg::ACC_W'(i);
    if (i < CELL_WIDTH) begin : g_in
      assign wm_c[i] = (p1_start >= NEG_I) && (p1_rem > POS_I);
    end else begin : g_out
      assign wm_c[i] = 1'b0;
    end
    if (K >= 0 && K < GLYPH_BITS && (GLYPH_BITS - 1 - K) < ogr_pkg::FONT_BITS) begin : g_fg
      assign fg_c[i] = rdata[GLYPH_BITS - 1 - K];
    end else begin : g_bg
      assign fg_c[i] = 1'b0;
    end
  end

  `OGR_ASSERT_IMPL(bk_row_range, active, row <= LAST_ROW_IDX, "glyph row past last")
  `OGR_ASSERT_NEXT(bk_glyph_end, last_issue && !load_draw, !active,
                   "back still busy after last row")

endmodule
